// ===== src/afk_pkg.sv =====
// ----------------------------------------------------------------------------
// afk_pkg: shared types, constants and helpers
// Angle reduction, coordinate rounding and the record types that pass
// between the front and back parts of the arm kinematics block.
// ----------------------------------------------------------------------------
package afk_pkg;

    localparam int ANG_W     = 14;   // raw joint angle, 1/16 degree, signed
    localparam int ANGR_W    = 13;   // reduced angle, 0 .. 5759
    localparam int LEN_W     = 12;   // link length, millimetres
    localparam int COORD_W   = 20;   // coordinate, 1/16 mm, signed
    localparam int SIN_W     = 18;   // Q16 sine, signed
    localparam int SIN_LAT   = 8;    // register stages in the sine unit
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_IDX_W  = 8;

    localparam int FIFO_DEPTH_DEF = 2;

    localparam int COORD_MAX = 327680;

    // ceil(2^35 / 45): t * 65536 / 1440 == (t * U_RECIP) >> 24 for t in 0..1440
    localparam logic [29:0] U_RECIP = 30'd763549742;

    localparam logic [CFG_IDX_W-1:0] REG_LINK1 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK2 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK3 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK4 = 8'd3;

    typedef logic [ANGR_W-1:0]          angle_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [SIN_W-1:0]    sin_t;

    typedef struct packed {
        angle_t yaw;
        angle_t shoulder;
        angle_t elbow;
        angle_t wrist;
    } pose_t;

    typedef struct packed {
        logic [LEN_W-1:0] link1;
        logic [LEN_W-1:0] link2;
        logic [LEN_W-1:0] link3;
        logic [LEN_W-1:0] link4;
    } len_cfg_t;

    // Reduce a raw 14-bit angle into one full turn.
    function automatic angle_t wrap_in(input logic signed [ANG_W-1:0] a);
        logic signed [14:0] v;
        v = {a[ANG_W-1], a};
        if (v < -15'sd5760) begin
            v = v + 15'sd11520;
        end else if (v < 15'sd0) begin
            v = v + 15'sd5760;
        end else if (v >= 15'sd5760) begin
            v = v - 15'sd5760;
        end
        return angle_t'(v[ANGR_W-1:0]);
    endfunction

    // Fold a sum that lies within one turn on either side back into 0 .. 5759.
    function automatic angle_t wrap_sum(input logic signed [14:0] s);
        logic signed [14:0] v;
        v = s;
        if (v < 15'sd0) begin
            v = v + 15'sd5760;
        end else if (v >= 15'sd5760) begin
            v = v - 15'sd5760;
        end
        return angle_t'(v[ANGR_W-1:0]);
    endfunction

    // Q16 millimetres to 1/16 mm, round half up, then clamp.
    function automatic coord_t to_coord(input logic signed [35:0] v);
        logic signed [36:0] r;
        r = ($signed({v[35], v}) + 37'sd2048) >>> 12;
        if (r > 37'sd327680) begin
            r = 37'sd327680;
        end else if (r < -37'sd327680) begin
            r = -37'sd327680;
        end
        return coord_t'(r[COORD_W-1:0]);
    endfunction

endpackage

// ===== src/afk_sine.sv =====
// ----------------------------------------------------------------------------
// afk_sine: pipelined Q16 sine of a reduced angle
// Quadrant folding followed by an odd polynomial in the quarter wave, at most
// one multiplication per register stage.
// ----------------------------------------------------------------------------
module afk_sine
    import afk_pkg::*;
(
    input  logic   aclk,
    input  logic   en,
    input  angle_t angle_i,
    output sin_t   sin_o
);

    logic [10:0]        t1_reg;
    logic               neg_reg [7];
    logic [16:0]        u2_reg, u3_reg, u4_reg, u5_reg, u6_reg;
    logic [16:0]        w3_reg, w4_reg, w5_reg;
    logic signed [15:0] p4_reg;
    logic signed [17:0] p5_reg;
    logic signed [18:0] p6_reg;
    sin_t               s7_reg;
    sin_t               s8_reg;

    logic [12:0]        t1_next;
    logic               neg1_next;
    logic [40:0]        u_prod;
    logic [33:0]        w_prod;
    logic signed [27:0] m4;
    logic signed [33:0] m5;
    logic signed [35:0] m6;
    logic signed [36:0] m7;

    // Quadrant folding.
    always_comb begin
        priority if (angle_i >= 13'd4320) begin
            t1_next   = 13'd5760 - angle_i;
            neg1_next = 1'b1;
        end else if (angle_i >= 13'd2880) begin
            t1_next   = angle_i - 13'd2880;
            neg1_next = 1'b1;
        end else if (angle_i >= 13'd1440) begin
            t1_next   = 13'd2880 - angle_i;
            neg1_next = 1'b0;
        end else begin
            t1_next   = angle_i;
            neg1_next = 1'b0;
        end
    end

    assign u_prod = {30'b0, t1_reg} * {11'b0, U_RECIP};
    assign w_prod = {17'b0, u2_reg} * {17'b0, u2_reg};
    assign m4     = -28'sd307 * $signed({11'b0, w3_reg});
    assign m5     = 34'(p4_reg) * $signed({17'b0, w4_reg});
    assign m6     = 36'(p5_reg) * $signed({19'b0, w5_reg});
    assign m7     = 37'(p6_reg) * $signed({20'b0, u6_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg     <= t1_next[10:0];
            neg_reg[0] <= neg1_next;
            for (int i = 1; i < 7; i++) begin
                neg_reg[i] <= neg_reg[i-1];
            end
            u2_reg <= u_prod[40:24];
            u3_reg <= u2_reg;
            w3_reg <= w_prod[32:16];
            u4_reg <= u3_reg;
            w4_reg <= w3_reg;
            p4_reg <= 16'sd5223 + 16'(m4 >>> 16);
            u5_reg <= u4_reg;
            w5_reg <= w4_reg;
            p5_reg <= -18'sd42334 + 18'(m5 >>> 16);
            u6_reg <= u5_reg;
            p6_reg <= 19'sd102954 + 19'(m6 >>> 16);
            s7_reg <= sin_t'(m7 >>> 16);
            s8_reg <= neg_reg[6] ? -s7_reg : s7_reg;
        end
    end

    assign sin_o = s8_reg;

endmodule

// ===== src/afk_front.sv =====
// ----------------------------------------------------------------------------
// afk_front: pose intake and queue
// Accepts poses, reduces each joint angle into one turn and holds them in a
// short queue for the back part.
// ----------------------------------------------------------------------------
module afk_front
    import afk_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output pose_t                pose_o,
    output logic                 pose_valid_o,
    input  logic                 pop_i
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pose_t            fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;
    pose_t            in_pose;

    assign s_tready     = (count_reg != CNT_W'(DEPTH));
    assign push         = s_tvalid && s_tready;
    assign pose_valid_o = (count_reg != '0);
    assign pop          = pop_i && pose_valid_o;
    assign pose_o       = fifo_mem[rd_ptr_reg];

    always_comb begin
        in_pose.yaw      = wrap_in(s_tdata[13:0]);
        in_pose.shoulder = wrap_in(s_tdata[27:14]);
        in_pose.elbow    = wrap_in(s_tdata[41:28]);
        in_pose.wrist    = wrap_in(s_tdata[55:42]);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= in_pose;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/afk_back.sv =====
// ----------------------------------------------------------------------------
// afk_back: segment pipeline
// Issues one operation per segment, evaluates sine and cosine, accumulates
// the planar reach and height, applies the yaw and emits the segments.
// ----------------------------------------------------------------------------
module afk_back
    import afk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pose_t                 pose_i,
    input  logic                  pose_valid_i,
    output logic                  pose_pop_o,
    input  len_cfg_t              len_i,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic adv;

    // Issue stage.
    logic [1:0] cnt_reg;
    logic       iv_reg;
    logic [1:0] ik_reg;
    angle_t     ang_reg;
    angle_t     ang_next;

    // Lane stage.
    logic       lv_reg;
    logic [1:0] lk_reg;
    angle_t     sa_reg, ca_reg;

    // Sine latency tracking.
    logic       dv_reg [SIN_LAT];
    logic [1:0] dk_reg [SIN_LAT];
    sin_t       sin_v, cos_v;

    // Geometry stages.
    logic               e0v_reg, e1v_reg, e2v_reg;
    logic [1:0]         e0k_reg, e1k_reg, e2k_reg;
    logic signed [30:0] hterm_reg, vterm_reg;
    sin_t               cy_e0_reg, sy_e0_reg, cy_e1_reg, sy_e1_reg;
    logic signed [32:0] h_reg, v_reg;
    logic signed [50:0] xp_reg, yp_reg;
    logic signed [32:0] z2_reg;
    logic [LEN_W-1:0]   len_sel;

    // Output register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    coord_t                ex_reg, ey_reg, ez_reg;
    coord_t                ex_c, ey_c, ez_c;

    assign adv        = !out_valid_reg || m_tready;
    assign pose_pop_o = adv && pose_valid_i && (cnt_reg == 2'd3);

    always_comb begin
        unique case (cnt_reg)
            2'd0: ang_next = pose_i.yaw;
            2'd1: ang_next = wrap_sum($signed({2'b0, pose_i.shoulder}) - 15'sd1440);
            2'd2: ang_next = wrap_sum($signed({2'b0, ang_reg}) + $signed({2'b0, pose_i.elbow}));
            2'd3: ang_next = wrap_sum($signed({2'b0, ang_reg}) + $signed({2'b0, pose_i.wrist}));
            default: ang_next = pose_i.yaw;
        endcase
    end

    always_comb begin
        unique case (dk_reg[SIN_LAT-1])
            2'd1:    len_sel = len_i.link2;
            2'd2:    len_sel = len_i.link3;
            2'd3:    len_sel = len_i.link4;
            default: len_sel = '0;
        endcase
    end

    afk_sine u_sin (.aclk(aclk), .en(adv), .angle_i(sa_reg), .sin_o(sin_v));
    afk_sine u_cos (.aclk(aclk), .en(adv), .angle_i(ca_reg), .sin_o(cos_v));

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            iv_reg        <= 1'b0;
            lv_reg        <= 1'b0;
            e0v_reg       <= 1'b0;
            e1v_reg       <= 1'b0;
            e2v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SIN_LAT; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            iv_reg <= pose_valid_i;
            if (pose_valid_i) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            lv_reg    <= iv_reg;
            dv_reg[0] <= lv_reg;
            for (int i = 1; i < SIN_LAT; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
            e0v_reg       <= dv_reg[SIN_LAT-1];
            e1v_reg       <= e0v_reg;
            e2v_reg       <= e1v_reg;
            out_valid_reg <= e2v_reg;
        end
    end

    assign ex_c = to_coord(36'(xp_reg >>> 16));
    assign ey_c = to_coord(36'(yp_reg >>> 16));
    assign ez_c = to_coord(36'(z2_reg));

    // Data path.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (pose_valid_i) begin
                ang_reg <= ang_next;
                ik_reg  <= cnt_reg;
            end
            lk_reg <= ik_reg;
            sa_reg <= ang_reg;
            ca_reg <= wrap_sum($signed({2'b0, ang_reg}) + 15'sd1440);
            dk_reg[0] <= lk_reg;
            for (int i = 1; i < SIN_LAT; i++) begin
                dk_reg[i] <= dk_reg[i-1];
            end

            e0k_reg   <= dk_reg[SIN_LAT-1];
            hterm_reg <= 31'($signed({1'b0, len_sel})) * 31'(cos_v);
            vterm_reg <= 31'($signed({1'b0, len_sel})) * 31'(sin_v);
            if (dv_reg[SIN_LAT-1] && dk_reg[SIN_LAT-1] == 2'd0) begin
                cy_e0_reg <= cos_v;
                sy_e0_reg <= sin_v;
            end

            e1k_reg   <= e0k_reg;
            cy_e1_reg <= cy_e0_reg;
            sy_e1_reg <= sy_e0_reg;
            if (e0v_reg) begin
                if (e0k_reg == 2'd0) begin
                    h_reg <= '0;
                    v_reg <= $signed({5'b0, len_i.link1, 16'b0});
                end else begin
                    h_reg <= h_reg + 33'(hterm_reg);
                    v_reg <= v_reg + 33'(vterm_reg);
                end
            end

            e2k_reg <= e1k_reg;
            xp_reg  <= 51'(cy_e1_reg) * 51'(h_reg);
            yp_reg  <= 51'(sy_e1_reg) * 51'(h_reg);
            z2_reg  <= v_reg;

            if (e2v_reg) begin
                ex_reg <= ex_c;
                ey_reg <= ey_c;
                ez_reg <= ez_c;
                if (e2k_reg == 2'd0) begin
                    out_data_reg <= {6'b0, ez_c, ey_c, ex_c, 60'b0, e2k_reg};
                end else begin
                    out_data_reg <= {6'b0, ez_c, ey_c, ex_c, ez_reg, ey_reg, ex_reg, e2k_reg};
                end
                out_last_reg <= (e2k_reg == 2'd3);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/arm_forward_kinematics_4dof.sv =====
// ----------------------------------------------------------------------------
// arm_forward_kinematics_4dof: forward kinematics of a yaw-pitch-pitch-pitch arm
// Turns one pose request into four link segment requests with start and end
// points.
// ----------------------------------------------------------------------------
// Each accepted pose yields four segment results, base link first, hand link
// last (tlast high). The back pipeline issues one segment operation per cycle
// while the result channel does not stall, and every operation runs through
// two shared sine units. A pose request is accepted while the pose queue has
// room; the queue (DEPTH entries) lets the input side keep taking poses while
// results are stalled. The first segment of a pose passes the pose queue, the
// issue and lane stages, the sine units, the geometry stages and the output
// register before it is offered. The user must write link lengths through
// the cfg port only while the block is idle; the block does not enforce this.
// Writes to an index beyond the fourth register are ignored.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_4dof
    import afk_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Pose input, tdata from bit 0: base_yaw, shoulder_pitch, elbow_pitch,
    // wrist_pitch (14 bits each, signed, 1/16 degree).
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Segment output, tdata from bit 0: segment_index (2), start_x, start_y,
    // start_z, end_x, end_y, end_z (20 bits each, signed, 1/16 mm), zero pad.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEN_W-1:0]      cfg_wdata
);

    len_cfg_t len_reg;
    pose_t    pose;
    logic     pose_valid;
    logic     pose_pop;

    // Link length registers, in millimetres.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINK1: len_reg.link1 <= cfg_wdata;
                REG_LINK2: len_reg.link2 <= cfg_wdata;
                REG_LINK3: len_reg.link3 <= cfg_wdata;
                REG_LINK4: len_reg.link4 <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // The front part reduces the joint angles and queues the pose.
    afk_front #(.DEPTH(DEPTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .pose_o       (pose),
        .pose_valid_o (pose_valid),
        .pop_i        (pose_pop)
    );

    // The back part runs the trigonometry and emits the segments.
    afk_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pose_i       (pose),
        .pose_valid_i (pose_valid),
        .pose_pop_o   (pose_pop),
        .len_i        (len_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

// ===== src/afk_checker.sv =====
// ----------------------------------------------------------------------------
// afk_checker: port-level checks for the arm kinematics block
// Watches the segment stream for framing and stall behavior.
// ----------------------------------------------------------------------------
module afk_checker
    import afk_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // A stalled segment request stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("segment request dropped while stalled");

    // The hand segment, and only it, closes a pose.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
        else $error("tlast does not match the hand segment");

    // The base segment starts at the origin.
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[61:2] == 60'b0)
        else $error("base segment does not start at the origin");

    // After a non-final segment is taken, the next one offered follows it.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)
        else $error("segment order broken");

endmodule

bind arm_forward_kinematics_4dof afk_checker u_afk_checker (.*);
